@@ rtl/core/sliding_window_sender_core_defines.svh @@
// ----------------------------------------------------------------------------
// Sliding window sender core - assertion macros
// Assertion property shorthands used by the sender core.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_SENDER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_SENDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SWS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SWS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/sws_pkg.sv @@
// ----------------------------------------------------------------------------
// Sliding window sender package
// Payload structs, field widths, item kinds and result status codes.
// ----------------------------------------------------------------------------
package sws_pkg;

   localparam int unsigned SEQ_W  = 6;
   localparam int unsigned LEN_W  = 16;
   localparam int unsigned PORT_W = 14;
   localparam int unsigned ADDR_W = 8;
   localparam int unsigned PAD_W  = 2;
   localparam int unsigned IDLE_W = 20;
   localparam int unsigned WIN_W  = 5;
   localparam int unsigned TO_W   = 16;

   // item kinds on the request channel
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_ACK   = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;

   // configuration register indexes
   localparam logic CSR_WINDOW_SIZE   = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   typedef enum logic [2:0] {
      STATUS_PACKET   = 3'd0,
      STATUS_ADVANCED = 3'd1,
      STATUS_IGNORED  = 3'd2,
      STATUS_FINISHED = 3'd3,
      STATUS_FAILED   = 3'd4,
      STATUS_BUSY     = 3'd5,
      STATUS_NO_ACT   = 3'd6
   } status_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ADDR_W-1:0] dest_addr;
      logic [PORT_W-1:0] port;
      logic [LEN_W-1:0]  xfer_bytes;
      logic [15:0]       ack_seq;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [SEQ_W-1:0] pkt_seq;
      logic [31:0]      header_word;
      logic [PAD_W-1:0] pad_bytes;
      logic             last_in_run;
   } rsp_type;

   // result of the packet count unit
   typedef struct packed {
      logic             done;
      logic [SEQ_W-1:0] total;
      logic [PAD_W-1:0] pad;
   } count_res_type;

endpackage

@@ rtl/core/sliding_window_sender_core.sv @@
// ----------------------------------------------------------------------------
// Sliding window sender core
// Go-back-N sender for one transfer at a time: opens a transfer, emits the
// window of packets, slides it on acks and resends it on timeouts.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one item per transfer (start, ack or tick). req_stall is high
//            while an item is being worked on; only one item is in flight.
//   rsp_*  : one or more results per item, last_in_run marks the final one.
//   csr_*  : register writes (window size, timeout), always ready; write only
//            while no item is in flight.
// Sequencing:
//   ack, tick without resend, and other single results: one result per item.
//   start: the packet count subtractor works out ceil(xfer_bytes / PAYLOAD_BYTES)
//   packets (at most MAX_PACKETS), then one window packet per cycle unless
//   rsp_stall holds it. resend tick: one window packet per cycle from the window
//   base, unless rsp_stall holds it.
// Reset clears the transfer state, window size returns to 10, timeout to 3.
// A stalled receiver holds the output register and the sequencer waits; the
// next result loads in the same cycle the held one is transferred.
// ----------------------------------------------------------------------------
`include "sliding_window_sender_core_defines.svh"

module sliding_window_sender_core #(
   parameter int unsigned MAX_PACKETS   = 44,
   parameter int unsigned PAYLOAD_BYTES = 1492
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  sws_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output sws_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [sws_pkg::TO_W-1:0]      csr_wdata
);

   localparam int unsigned SW = sws_pkg::SEQ_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_COUNT  = 4'b0010,
      ST_EMIT   = 4'b0100,
      ST_SINGLE = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic                          active_ff, active_in;
   logic [sws_pkg::ADDR_W-1:0]    peer_addr_ff, peer_addr_in;
   logic [sws_pkg::PORT_W-1:0]    peer_port_ff, peer_port_in;
   logic [SW-1:0]                 total_ff, total_in;
   logic [SW-1:0]                 base_ff, base_in;
   logic [SW-1:0]                 top_ff, top_in;
   logic                          ack_seen_ff, ack_seen_in;
   logic [sws_pkg::IDLE_W-1:0]    idle_ff, idle_in;
   logic [sws_pkg::PAD_W-1:0]     final_pad_ff, final_pad_in;
   logic [SW-1:0]                 emit_idx_ff, emit_idx_in;
   sws_pkg::status_type           pend_status_ff, pend_status_in;
   logic [sws_pkg::WIN_W-1:0]     window_size_ff, window_size_in;
   logic [sws_pkg::TO_W-1:0]      timeout_ff, timeout_in;

   logic                          req_take;
   logic [sws_pkg::WIN_W-1:0]     eff_win;
   logic [SW:0]                   ack_top;
   logic [SW-1:0]                 base_next;
   logic                          ack_match;
   logic [sws_pkg::IDLE_W-1:0]    idle_inc;
   logic [sws_pkg::IDLE_W-1:0]    to_ext;
   logic [sws_pkg::IDLE_W-1:0]    to_x5;
   logic                          cnt_start;
   sws_pkg::count_res_type        cnt_res;
   logic                          rsp_load;
   logic                          rsp_load_ok;
   sws_pkg::rsp_type              rsp_load_data;
   logic [SW-1:0]                 start_top;
   logic                          pkt_last;
   logic [sws_pkg::PAD_W-1:0]     pkt_pad;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // clamp the window into 1..16
   always_comb begin
      if (window_size_ff == '0) begin
         eff_win = sws_pkg::WIN_W'(1);
      end else if (window_size_ff > sws_pkg::WIN_W'(16)) begin
         eff_win = sws_pkg::WIN_W'(16);
      end else begin
         eff_win = window_size_ff;
      end
   end

   // ack check and the window top after a slide
   assign ack_match = active_ff && (req_data.dest_addr == peer_addr_ff) &&
                      (req_data.port == peer_port_ff) &&
                      (req_data.ack_seq == {{(16-SW){1'b0}}, base_ff});
   assign base_next = base_ff + SW'(1);
   assign ack_top   = {1'b0, base_next} + (SW+1)'(eff_win);

   // tick count and timeout limits
   assign idle_inc = (idle_ff == '1) ? idle_ff : idle_ff + sws_pkg::IDLE_W'(1);
   assign to_ext   = sws_pkg::IDLE_W'(timeout_ff);
   assign to_x5    = (to_ext << 2) + to_ext;

   // first window top after the count
   assign start_top = ({1'b0, eff_win} < cnt_res.total) ? SW'(eff_win) : cnt_res.total;

   // current packet of the window loop
   assign pkt_last = ({1'b0, emit_idx_ff} + (SW+1)'(1)) == {1'b0, top_ff};
   assign pkt_pad  = ((emit_idx_ff + SW'(1)) == total_ff) ? final_pad_ff : '0;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      peer_addr_in   = peer_addr_ff;
      peer_port_in   = peer_port_ff;
      total_in       = total_ff;
      base_in        = base_ff;
      top_in         = top_ff;
      ack_seen_in    = ack_seen_ff;
      idle_in        = idle_ff;
      final_pad_in   = final_pad_ff;
      emit_idx_in    = emit_idx_ff;
      pend_status_in = pend_status_ff;
      window_size_in = window_size_ff;
      timeout_in     = timeout_ff;
      cnt_start      = 1'b0;
      rsp_load       = 1'b0;
      rsp_load_data  = '0;

      // register writes
      if (csr_valid && csr_ready) begin
         if (csr_index == sws_pkg::CSR_WINDOW_SIZE) begin
            window_size_in = csr_wdata[sws_pkg::WIN_W-1:0];
         end else begin
            timeout_in = csr_wdata;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in       = ST_SINGLE;
               pend_status_in = sws_pkg::STATUS_NO_ACT;
               case (req_data.kind)
                  sws_pkg::KIND_START: begin
                     if (active_ff) begin
                        pend_status_in = sws_pkg::STATUS_BUSY;
                     end else if (req_data.xfer_bytes != '0) begin
                        cnt_start    = 1'b1;
                        peer_addr_in = req_data.dest_addr;
                        peer_port_in = req_data.port;
                        state_in     = ST_COUNT;
                     end
                  end
                  sws_pkg::KIND_ACK: begin
                     if (!ack_match) begin
                        pend_status_in = sws_pkg::STATUS_IGNORED;
                     end else begin
                        base_in     = base_next;
                        top_in      = (ack_top < {1'b0, total_ff}) ? ack_top[SW-1:0] :
                                      total_ff;
                        ack_seen_in = 1'b1;
                        if (base_next >= total_ff) begin
                           active_in      = 1'b0;
                           pend_status_in = sws_pkg::STATUS_FINISHED;
                        end else begin
                           pend_status_in = sws_pkg::STATUS_ADVANCED;
                        end
                     end
                  end
                  sws_pkg::KIND_TICK: begin
                     if (active_ff) begin
                        idle_in = idle_inc;
                        if (idle_inc > to_ext) begin
                           if (ack_seen_ff) begin
                              idle_in     = '0;
                              emit_idx_in = base_ff;
                              state_in    = ST_EMIT;
                           end else if (idle_inc > to_x5) begin
                              active_in      = 1'b0;
                              pend_status_in = sws_pkg::STATUS_FAILED;
                           end else begin
                              emit_idx_in = base_ff;
                              state_in    = ST_EMIT;
                           end
                        end
                     end
                  end
                  default: begin
                     pend_status_in = sws_pkg::STATUS_NO_ACT;
                  end
               endcase
            end
         end
         ST_COUNT: begin
            // open the transfer once the count is known
            if (cnt_res.done) begin
               active_in    = 1'b1;
               total_in     = cnt_res.total;
               final_pad_in = cnt_res.pad;
               base_in      = '0;
               top_in       = start_top;
               ack_seen_in  = 1'b0;
               idle_in      = '0;
               emit_idx_in  = '0;
               state_in     = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // emit one window packet per free output slot
            rsp_load                  = 1'b1;
            rsp_load_data.status      = sws_pkg::STATUS_PACKET;
            rsp_load_data.pkt_seq     = emit_idx_ff;
            rsp_load_data.header_word = {pkt_pad, peer_port_ff, {(16-SW){1'b0}}, emit_idx_ff};
            rsp_load_data.pad_bytes   = pkt_pad;
            rsp_load_data.last_in_run = pkt_last;
            if (rsp_load_ok) begin
               if (pkt_last) begin
                  state_in = ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + SW'(1);
               end
            end
         end
         ST_SINGLE: begin
            rsp_load                  = 1'b1;
            rsp_load_data.status      = pend_status_ff;
            rsp_load_data.last_in_run = 1'b1;
            if (rsp_load_ok) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         active_ff      <= 1'b0;
         peer_addr_ff   <= '0;
         peer_port_ff   <= '0;
         total_ff       <= '0;
         base_ff        <= '0;
         top_ff         <= '0;
         ack_seen_ff    <= 1'b0;
         idle_ff        <= '0;
         final_pad_ff   <= '0;
         window_size_ff <= sws_pkg::WIN_W'(10);
         timeout_ff     <= sws_pkg::TO_W'(3);
      end else begin
         state_ff       <= state_in;
         active_ff      <= active_in;
         peer_addr_ff   <= peer_addr_in;
         peer_port_ff   <= peer_port_in;
         total_ff       <= total_in;
         base_ff        <= base_in;
         top_ff         <= top_in;
         ack_seen_ff    <= ack_seen_in;
         idle_ff        <= idle_in;
         final_pad_ff   <= final_pad_in;
         window_size_ff <= window_size_in;
         timeout_ff     <= timeout_in;
      end
      emit_idx_ff    <= emit_idx_in;
      pend_status_ff <= pend_status_in;
   end

   sws_pkt_count #(
      .MAX_PACKETS   (MAX_PACKETS),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_pkt_count (
      .clock  (clock),
      .reset  (reset),
      .start  (cnt_start),
      .length (req_data.xfer_bytes),
      .result (cnt_res)
   );

   sws_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (rsp_load),
      .load_data (rsp_load_data),
      .load_ok   (rsp_load_ok),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // check window bookkeeping
   `SWS_ASSERT_SAME(a_base_below_total, clock, reset, active_ff, base_ff < total_ff, "window base not below packet count")
   `SWS_ASSERT_SAME(a_top_in_range, clock, reset, active_ff, (top_ff > base_ff) && (top_ff <= total_ff), "window top out of range")
   `SWS_ASSERT_SAME(a_count_when_closed, clock, reset, state_ff == ST_COUNT, !active_ff, "packet count while a transfer is open")
   `SWS_ASSERT_NEXT(a_emit_fills_slot, clock, reset, (state_ff == ST_EMIT) && rsp_load_ok, rsp_valid, "window packet not presented")

endmodule

@@ rtl/core/sws_pkt_count.sv @@
// ----------------------------------------------------------------------------
// Packet count unit
// Works out ceil(length / payload) by repeated subtraction, one payload per
// cycle through a single subtractor, and the pad of the final packet.
// ----------------------------------------------------------------------------
module sws_pkt_count #(
   parameter int unsigned MAX_PACKETS   = 44,
   parameter int unsigned PAYLOAD_BYTES = 1492
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sws_pkg::LEN_W-1:0]     length,
   output sws_pkg::count_res_type        result
);

   localparam logic [sws_pkg::LEN_W:0]   PB_W  = (sws_pkg::LEN_W+1)'(PAYLOAD_BYTES);
   localparam logic [sws_pkg::SEQ_W-1:0] MAX_W = sws_pkg::SEQ_W'(MAX_PACKETS);
   localparam logic [sws_pkg::SEQ_W-1:0] ONE_W = sws_pkg::SEQ_W'(1);

   logic                         busy_ff, busy_in;
   logic [sws_pkg::LEN_W-1:0]    acc_ff, acc_in;
   logic [sws_pkg::SEQ_W-1:0]    cnt_ff, cnt_in;
   logic                         step;
   logic [sws_pkg::LEN_W:0]      rem;
   logic [sws_pkg::PAD_W-1:0]    pad;

   // one more payload fits below the remaining length and the count is below MAX_PACKETS
   assign step = ({1'b0, acc_ff} > PB_W) && (cnt_ff < MAX_W);

   // remainder of the final packet: first packet carries two bytes less
   assign rem = {1'b0, acc_ff} + (sws_pkg::LEN_W+1)'(2);

   always_comb begin
      if (cnt_ff == ONE_W) begin
         pad = sws_pkg::PAD_W'(2'd0 - acc_ff[1:0]);
      end else if (rem < PB_W) begin
         pad = sws_pkg::PAD_W'(2'd0 - rem[1:0]);
      end else begin
         pad = '0;
      end
   end

   // advance the subtract loop
   always_comb begin
      busy_in = busy_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = length;
         cnt_in  = ONE_W;
      end else if (busy_ff) begin
         if (step) begin
            acc_in = sws_pkg::LEN_W'({1'b0, acc_ff} - PB_W);
            cnt_in = cnt_ff + ONE_W;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign result.done  = busy_ff && !step;
   assign result.total = cnt_ff;
   assign result.pad   = pad;

endmodule

@@ rtl/core/sws_rsp_reg.sv @@
// ----------------------------------------------------------------------------
// Result output register
// Holds one result towards the response channel and frees the slot on
// transfer, so a new result may load in the same cycle.
// ----------------------------------------------------------------------------
module sws_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  sws_pkg::rsp_type load_data,
   output logic             load_ok,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sws_pkg::rsp_type rsp_data
);

   logic             valid_ff, valid_in;
   sws_pkg::rsp_type data_ff, data_in;

   assign load_ok = !valid_ff || !rsp_stall;

   // hold while stalled, replace or drop once transferred
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load && load_ok) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
